// File: rtl/mmh_pkg.sv
// ----------------------------------------------------------------------------
// Masked multichannel histogram package
// Shared constants, types and a helper function for the histogram block.
// ----------------------------------------------------------------------------
package mmh_pkg;

    localparam int DEF_MAX_BINS      = 1024;
    localparam int DEF_CHANNEL_SLOTS = 5;
    localparam int DEF_COUNT_BITS    = 48;
    localparam int DEF_FRAC_BITS     = 16;

    localparam int SAMPLE_W   = 17;
    localparam int KIND_W     = 2;
    localparam int RCH_W      = 3;
    localparam int RBIN_W     = 10;
    localparam int OUT_CNT_W  = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam int ONE16      = 65536;

    // Input kinds.
    localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Back end command ops.
    localparam logic [1:0] OP_BUMP  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COMP_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_BINS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_EN    = 2'd2;

    // Reply kinds.
    localparam logic REPLY_READ  = 1'b0;
    localparam logic REPLY_CLEAR = 1'b1;

    // Back end states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_READ,
        ST_REPLY
    } t_be_state;

    // Saturate a 17-bit fraction at 1.0.
    function automatic logic [SAMPLE_W-1:0] clamp_one(input logic [SAMPLE_W-1:0] v);
        clamp_one = (v > SAMPLE_W'(ONE16)) ? SAMPLE_W'(ONE16) : v;
    endfunction

endpackage

// File: rtl/mmh_front.sv
// ----------------------------------------------------------------------------
// Histogram front end
// Classifies each item, computes bins and weights, and emits bin updates.
// ----------------------------------------------------------------------------
module mmh_front #(
    parameter int MAX_BINS      = mmh_pkg::DEF_MAX_BINS,
    parameter int CHANNEL_SLOTS = mmh_pkg::DEF_CHANNEL_SLOTS,
    parameter int BIN_W         = $clog2(MAX_BINS),
    parameter int CH_W          = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [mmh_pkg::KIND_W-1:0]      i_kind,
    input  logic [mmh_pkg::SAMPLE_W-1:0]    i_sa,
    input  logic [mmh_pkg::SAMPLE_W-1:0]    i_sb,
    input  logic [mmh_pkg::SAMPLE_W-1:0]    i_sc,
    input  logic [mmh_pkg::SAMPLE_W-1:0]    i_sd,
    input  logic [mmh_pkg::SAMPLE_W-1:0]    i_mw,
    input  logic [mmh_pkg::RCH_W-1:0]       i_rch,
    input  logic [mmh_pkg::RBIN_W-1:0]      i_rbin,
    input  logic [2:0]                      i_comp,
    input  logic                            i_wide,
    input  logic                            i_mask_en,
    // Command output toward the back end: op, channel, bin, increment, valid flag.
    output logic                            o_cmd_valid,
    input  logic                            i_cmd_ready,
    output logic [1:0]                      o_cmd_op,
    output logic [CH_W-1:0]                 o_cmd_ch,
    output logic [BIN_W-1:0]                o_cmd_bin,
    output logic [mmh_pkg::SAMPLE_W-1:0]    o_cmd_inc,
    output logic                            o_cmd_ok
);
    import mmh_pkg::*;

    // Stage 1: registered pixel, clamped values and weight product.
    logic                r_busy;
    logic [KIND_W-1:0]   r_kind;
    logic [SAMPLE_W-1:0] r_s [4];
    logic [SAMPLE_W-1:0] r_m;
    logic [33:0]         r_aw_prod;
    logic [RCH_W-1:0]    r_rch;
    logic [RBIN_W-1:0]   r_rbin;
    logic [2:0]          r_step, n_step;
    logic [2:0]          r_last;
    logic [2:0]          r_comp_q;
    logic                r_wide_q;

    logic [SAMPLE_W-1:0] w_m, w_alpha;
    logic [2:0]          w_last;

    always_comb begin
        w_m     = i_mask_en ? clamp_one(i_mw) : SAMPLE_W'(ONE16);
        w_alpha = (i_comp == 3'd4) ? clamp_one(i_sd) : clamp_one(i_sb);
        // Number of updates minus one for a pixel.
        case (i_comp)
            3'd1:    w_last = 3'd0;
            3'd2:    w_last = 3'd1;
            3'd3:    w_last = 3'd3;
            3'd4:    w_last = 3'd4;
            default: w_last = 3'd0;
        endcase
    end

    assign o_ready = !r_busy;

    // Per-step selection.
    logic [SAMPLE_W-1:0] w_sel, w_inc, w_aw, w_max;
    logic [CH_W-1:0]     w_ch;
    logic                w_ok;
    logic [1:0]          w_op;

    always_comb begin
        w_aw  = r_aw_prod[32:16];
        w_max = (r_s[0] > r_s[1]) ? r_s[0] : r_s[1];
        w_max = (r_s[2] > w_max) ? r_s[2] : w_max;
        w_sel = r_s[0];
        w_inc = r_m;
        w_ch  = '0;
        w_ok  = 1'b1;
        w_op  = OP_BUMP;
        if (r_kind == KIND_READ) begin
            w_op = OP_READ;
        end else if (r_kind == KIND_CLEAR) begin
            w_op = OP_CLEAR;
        end else begin
            case (r_last)
                3'd0: begin
                    w_sel = r_s[0];
                    w_ch  = '0;
                    w_ok  = (r_comp_q == 3'd1);
                end
                3'd1: begin
                    w_sel = (r_step == 3'd0) ? r_s[0] : r_s[1];
                    w_ch  = CH_W'(r_step);
                    w_inc = (r_step == 3'd0) ? w_aw : r_m;
                end
                default: begin
                    // Color pixels: channels 1..3, alpha slot (RGBA only), then max on channel 0.
                    if (r_step == r_last) begin
                        w_sel = w_max;
                        w_ch  = '0;
                    end else if (r_step == 3'd3) begin
                        w_sel = r_s[3];
                        w_ch  = CH_W'(4);
                    end else begin
                        w_sel = r_s[r_step[1:0]];
                        w_ch  = CH_W'(r_step + 3'd1);
                    end
                    w_inc = (r_last == 3'd4 && r_step != 3'd3) ? w_aw : r_m;
                end
            endcase
            if (int'(w_ch) >= CHANNEL_SLOTS) w_ok = 1'b0;
        end
    end

    // Bin index: floor(s * (B*10000-1) / (65536*10000)) for B = 256 or 1024.
    // With s*B = 65536*q + r the index is q, one less when 10000*r < s.
    localparam int BW = (MAX_BINS < 1024) ? MAX_BINS : 1024;
    logic [31:0]      w_b;
    logic [31:0]      w_prod;
    logic [15:0]      w_rem;
    logic [15:0]      w_idx;
    logic             w_borrow;
    logic [BIN_W-1:0] w_bin;
    always_comb begin
        w_b      = r_wide_q ? 32'(BW) : 32'd256;
        w_prod   = r_wide_q ? 32'(w_sel) * 32'(BW) : (32'(w_sel) << 8);
        w_rem    = w_prod[15:0];
        w_borrow = (32'(w_rem) * 32'd10000) < 32'(w_sel);
        w_idx    = w_prod[31:16] - 16'(w_borrow);
        w_bin    = (32'(w_idx) >= w_b) ? BIN_W'(w_b - 32'd1) : BIN_W'(w_idx);
    end

    always_comb begin
        o_cmd_valid = r_busy;
        o_cmd_op    = w_op;
        o_cmd_ch    = (w_op == OP_READ) ? CH_W'(r_rch) : w_ch;
        o_cmd_bin   = (w_op == OP_READ) ? BIN_W'(r_rbin) : w_bin;
        o_cmd_inc   = w_inc;
        if (w_op == OP_READ) begin
            o_cmd_ok = (r_rch <= RCH_W'(r_comp_q)) && (int'(r_rch) < CHANNEL_SLOTS) &&
                       (int'(r_rbin) < (r_wide_q ? BW : 256)) && (int'(r_rbin) < MAX_BINS);
        end else begin
            o_cmd_ok = w_ok && (r_comp_q >= 3'd1) && (r_comp_q <= 3'd4);
        end
        n_step = r_step + 3'd1;
    end

    // Item sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (!r_busy) begin
            if (i_valid && i_kind != KIND_UNUSED) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end
        end else if (i_cmd_ready) begin
            if (w_op != OP_BUMP || r_step == r_last) r_busy <= 1'b0;
            r_step <= n_step;
        end
    end

    // Payload capture.
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_valid) begin
            r_kind    <= i_kind;
            r_s[0]    <= clamp_one(i_sa);
            r_s[1]    <= clamp_one(i_sb);
            r_s[2]    <= clamp_one(i_sc);
            r_s[3]    <= clamp_one(i_sd);
            r_m       <= w_m;
            r_aw_prod <= 34'(w_alpha) * 34'(w_m);
            r_rch     <= i_rch;
            r_rbin    <= i_rbin;
            r_last    <= w_last;
            r_comp_q  <= i_comp;
            r_wide_q  <= i_wide;
        end
    end

endmodule

// File: rtl/mmh_back.sv
// ----------------------------------------------------------------------------
// Histogram back end
// Owns the bin memory; performs bumps, reads and clear sweeps.
// ----------------------------------------------------------------------------
module mmh_back #(
    parameter int MAX_BINS      = mmh_pkg::DEF_MAX_BINS,
    parameter int CHANNEL_SLOTS = mmh_pkg::DEF_CHANNEL_SLOTS,
    parameter int COUNT_BITS    = mmh_pkg::DEF_COUNT_BITS,
    parameter int FRAC_BITS     = mmh_pkg::DEF_FRAC_BITS,
    parameter int BIN_W         = $clog2(MAX_BINS),
    parameter int CH_W          = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  logic [1:0]                    i_cmd_op,
    input  logic [CH_W-1:0]               i_cmd_ch,
    input  logic [BIN_W-1:0]              i_cmd_bin,
    input  logic [mmh_pkg::SAMPLE_W-1:0]  i_cmd_inc,
    input  logic                          i_cmd_ok,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output logic                          o_kind,
    output logic [mmh_pkg::OUT_CNT_W-1:0] o_count
);
    import mmh_pkg::*;

    localparam int DEPTH  = CHANNEL_SLOTS * MAX_BINS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int INC_W  = SAMPLE_W + 24;

    logic [COUNT_BITS-1:0] r_mem [DEPTH];
    logic [COUNT_BITS-1:0] r_rdata;
    t_be_state             r_state, n_state;
    logic [ADDR_W-1:0]     r_addr;
    logic [ADDR_W:0]       r_clr;
    logic [INC_W-1:0]      r_inc;
    logic                  r_ok, r_op_read, r_rmw;
    logic                  r_reply_kind;

    logic [ADDR_W-1:0] w_addr;
    logic [INC_W-1:0]  w_inc;
    logic [COUNT_BITS:0] w_sum;
    logic [COUNT_BITS-1:0] w_new;
    logic w_take;

    always_comb begin
        w_addr = ADDR_W'(32'(i_cmd_ch) * 32'(MAX_BINS) + 32'(i_cmd_bin));
        if (FRAC_BITS >= 16) w_inc = INC_W'(i_cmd_inc) << (FRAC_BITS - 16);
        else                 w_inc = INC_W'(i_cmd_inc) >> (16 - FRAC_BITS);
        w_sum = (COUNT_BITS+1)'(r_rdata) + (COUNT_BITS+1)'(r_inc);
        w_new = w_sum[COUNT_BITS] ? '1 : w_sum[COUNT_BITS-1:0];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == (ADDR_W+1)'(DEPTH - 1))
                          n_state = r_op_read ? ST_RUN : ST_REPLY;
            ST_RUN:   if (i_cmd_valid && !r_rmw) begin
                          if (i_cmd_op == OP_READ) n_state = ST_READ;
                          else if (i_cmd_op == OP_CLEAR) n_state = ST_CLEAR;
                      end
            ST_READ:  n_state = ST_REPLY;
            ST_REPLY: if (i_tready) n_state = ST_RUN;
            default:  n_state = ST_RUN;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd_ready = (r_state == ST_RUN) && !r_rmw;
        w_take      = o_cmd_ready && i_cmd_valid;
        o_tvalid    = (r_state == ST_REPLY);
        o_kind      = r_reply_kind;
        o_count     = (r_reply_kind == REPLY_READ && r_ok) ? OUT_CNT_W'(r_rdata) : '0;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_op_read <= 1'b1;
            r_rmw     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            else r_clr <= '0;
            r_rmw <= w_take && i_cmd_op == OP_BUMP && i_cmd_ok;
            if (w_take && i_cmd_op == OP_CLEAR) r_op_read <= 1'b0;
            else if (r_state == ST_REPLY) r_op_read <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_addr       <= w_addr;
            r_inc        <= w_inc;
            r_ok         <= i_cmd_ok;
            r_reply_kind <= (i_cmd_op == OP_CLEAR) ? REPLY_CLEAR : REPLY_READ;
        end
    end

    // Bin memory: one read and one write port.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            r_mem[r_clr[ADDR_W-1:0]] <= '0;
        end else if (r_rmw) begin
            r_mem[r_addr] <= w_new;
        end
        r_rdata <= r_mem[w_take ? w_addr : r_addr];
    end

endmodule

// File: rtl/masked_multichannel_histogram_top.sv
// ----------------------------------------------------------------------------
// Masked multichannel histogram top level
// Per-channel weighted histogram with bin reads and whole-store clears.
// ----------------------------------------------------------------------------
// Items arrive on the s_axis channel; kind selects a pixel, a bin read or a
// clear. Pixels produce no reply. A read returns one m_axis transfer with the
// bin count (tuser 0); a clear returns one transfer with tuser 1 when done.
// Configuration is written through the cfg channel; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// A pixel holds the front end for one bin update per channel it touches (1
// to 5 updates); each valid update is a read-modify-write, and the back end
// takes no new command until its write is done. A pixel with a bad component
// count issues one bump that leaves the store alone. A read's reply follows the
// ST_READ and ST_REPLY states. A clear sweeps the memory one entry per cycle,
// covering all CHANNEL_SLOTS*MAX_BINS entries (5120 by default). After reset
// the same sweep runs before the first item is carried out; that item may be
// taken and wait in the front end. When the receiver stalls the reply holds
// and the block stops taking further commands for the back end.
// ----------------------------------------------------------------------------
module masked_multichannel_histogram_top #(
    parameter int MAX_BINS      = mmh_pkg::DEF_MAX_BINS,
    parameter int CHANNEL_SLOTS = mmh_pkg::DEF_CHANNEL_SLOTS,
    parameter int COUNT_BITS    = mmh_pkg::DEF_COUNT_BITS,
    parameter int FRAC_BITS     = mmh_pkg::DEF_FRAC_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tuser: kind [1:0]
    input  logic [1:0]   s_axis_tuser,
    // tdata: sample_a [16:0], sample_b [33:17], sample_c [50:34],
    // sample_d [67:51], mask_weight [84:68], read_channel [87:85],
    // read_bin [97:88], zero fill to 104 bits
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tuser: reply_kind [0]
    output logic         m_axis_tuser,
    // tdata: bin_count [47:0]
    output logic [47:0]  m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [2:0]   i_cfg_data
);
    import mmh_pkg::*;

    localparam int BIN_W = $clog2(MAX_BINS);
    localparam int CH_W  = 3;

    logic [2:0] r_comp;
    logic       r_wide, r_mask;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comp <= 3'd1;
            r_wide <= 1'b0;
            r_mask <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_COMP_COUNT: r_comp <= i_cfg_data;
                REG_WIDE_BINS:  r_wide <= i_cfg_data[0];
                REG_MASK_EN:    r_mask <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic                c_valid, c_ready, c_ok;
    logic [1:0]          c_op;
    logic [CH_W-1:0]     c_ch;
    logic [BIN_W-1:0]    c_bin;
    logic [SAMPLE_W-1:0] c_inc;

    mmh_front #(
        .MAX_BINS(MAX_BINS), .CHANNEL_SLOTS(CHANNEL_SLOTS),
        .BIN_W(BIN_W), .CH_W(CH_W)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_kind(s_axis_tuser),
        .i_sa(s_axis_tdata[16:0]), .i_sb(s_axis_tdata[33:17]),
        .i_sc(s_axis_tdata[50:34]), .i_sd(s_axis_tdata[67:51]),
        .i_mw(s_axis_tdata[84:68]), .i_rch(s_axis_tdata[87:85]),
        .i_rbin(s_axis_tdata[97:88]),
        .i_comp(r_comp), .i_wide(r_wide), .i_mask_en(r_mask),
        .o_cmd_valid(c_valid), .i_cmd_ready(c_ready), .o_cmd_op(c_op),
        .o_cmd_ch(c_ch), .o_cmd_bin(c_bin), .o_cmd_inc(c_inc), .o_cmd_ok(c_ok)
    );

    mmh_back #(
        .MAX_BINS(MAX_BINS), .CHANNEL_SLOTS(CHANNEL_SLOTS),
        .COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS),
        .BIN_W(BIN_W), .CH_W(CH_W)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(c_valid), .o_cmd_ready(c_ready), .i_cmd_op(c_op),
        .i_cmd_ch(c_ch), .i_cmd_bin(c_bin), .i_cmd_inc(c_inc), .i_cmd_ok(c_ok),
        .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready),
        .o_kind(m_axis_tuser), .o_count(m_axis_tdata)
    );

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// Masked multichannel histogram testbench
// Drives pixels, bin reads and clears under bursty input and a stalling
// receiver, predicts every reply from a model of the bin store, and checks
// each reply in order.
// ----------------------------------------------------------------------------
module tb;
    import mmh_pkg::*;

    localparam int NSLOT     = 5;
    localparam int NBIN      = 1024;
    localparam int IDLE_WAIT = 40;
    localparam int WDOG_MAX  = 40000;
    localparam int LONG_HOLD = 400;

    typedef struct packed {
        logic        rkind;
        logic [47:0] cnt;
    } t_reply;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [1:0]   s_axis_tuser = '0;
    logic [103:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic         m_axis_tuser;
    logic [47:0]  m_axis_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = '0;
    logic [2:0]   i_cfg_data = '0;

    // Model state: bin counts and register copies.
    logic [47:0]  hist_mem [0:NSLOT-1][0:NBIN-1];
    logic [2:0]   m_comp = 3'd1;
    logic         m_wide = 1'b0;
    logic         m_mask = 1'b0;
    t_reply       reply_q [$];

    int  mismatches = 0;
    int  burst_left = 0;
    int  hold_req = 0;
    int  long_req = 0;
    int  long_seen = 0;
    int  idle_cycles = 0;
    int  last_ch = 0;
    int  last_bin = 0;

    masked_multichannel_histogram_top dut (.*);

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Histogram model.
    // ------------------------------------------------------------------
    function automatic logic [16:0] sat_one(input logic [16:0] v);
        return (v > 17'd65536) ? 17'd65536 : v;
    endfunction

    function automatic int bin_index(input logic [16:0] s);
        longint unsigned nb, idx;
        nb  = m_wide ? 1024 : 256;
        idx = (longint'(sat_one(s)) * (nb * 10000 - 1)) / (64'd65536 * 10000);
        return (idx >= nb) ? int'(nb - 1) : int'(idx);
    endfunction

    function automatic void add_count(input int ch, input int bn, input logic [16:0] inc);
        logic [47:0] cur;
        cur = hist_mem[ch][bn];
        hist_mem[ch][bn] = ({31'd0, inc} > 48'hFFFF_FFFF_FFFF - cur) ?
                           48'hFFFF_FFFF_FFFF : cur + inc;
        last_ch  = ch;
        last_bin = bn;
    endfunction

    function automatic void wipe_hist();
        for (int c = 0; c < NSLOT; c++)
            for (int b = 0; b < NBIN; b++)
                hist_mem[c][b] = '0;
    endfunction

    // Apply one accepted item to the model and queue its reply, if any.
    function automatic void predict_item(input logic [1:0] k, input logic [103:0] d);
        logic [16:0] sa, sb, sc, sd, mw, w, aw, mx;
        logic [2:0]  rch;
        logic [9:0]  rbin;
        t_reply      r;
        sa = d[16:0]; sb = d[33:17]; sc = d[50:34]; sd = d[67:51]; mw = d[84:68];
        rch = d[87:85]; rbin = d[97:88];
        w  = m_mask ? sat_one(mw) : 17'd65536;
        mx = (sa > sb) ? sa : sb;
        mx = (sc > mx) ? sc : mx;
        if (k == KIND_PIXEL) begin
            case (m_comp)
                3'd1: add_count(0, bin_index(sa), w);
                3'd2: begin
                    aw = 17'((34'(sat_one(sb)) * w) >> 16);
                    add_count(0, bin_index(sa), aw);
                    add_count(1, bin_index(sb), w);
                end
                3'd3: begin
                    add_count(1, bin_index(sa), w);
                    add_count(2, bin_index(sb), w);
                    add_count(3, bin_index(sc), w);
                    add_count(0, bin_index(mx), w);
                end
                3'd4: begin
                    aw = 17'((34'(sat_one(sd)) * w) >> 16);
                    add_count(1, bin_index(sa), aw);
                    add_count(2, bin_index(sb), aw);
                    add_count(3, bin_index(sc), aw);
                    add_count(4, bin_index(sd), w);
                    add_count(0, bin_index(mx), aw);
                end
                default: ;
            endcase
        end else if (k == KIND_READ) begin
            r.rkind = REPLY_READ;
            r.cnt   = '0;
            if (rch <= m_comp && rch < NSLOT && int'(rbin) < (m_wide ? 1024 : 256))
                r.cnt = hist_mem[rch][rbin];
            reply_q.push_back(r);
        end else if (k == KIND_CLEAR) begin
            wipe_hist();
            r.rkind = REPLY_CLEAR;
            r.cnt   = '0;
            reply_q.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side: one item per call, sent in bursts with random gaps.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] k, input logic [16:0] sa, input logic [16:0] sb,
                             input logic [16:0] sc, input logic [16:0] sd,
                             input logic [16:0] mw, input logic [2:0] rch,
                             input logic [9:0] rbin);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= k;
        s_axis_tdata  <= {6'd0, rbin, rch, mw, sd, sc, sb, sa};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_item(k, {6'd0, rbin, rch, mw, sd, sc, sb, sa});
    endtask

    task automatic send_read(input int ch, input int bn);
        send_item(KIND_READ, '0, '0, '0, '0, '0, 3'(ch), 10'(bn));
    endtask

    // Stop sending, wait for every reply and let in-flight pixels finish.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    // Valid stays high between back-to-back writes; the caller drops it.
    task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_COMP_COUNT) m_comp = val;
        else if (idx == REG_WIDE_BINS) m_wide = val[0];
        else if (idx == REG_MASK_EN) m_mask = val[0];
    endtask

    task automatic set_mode(input logic [2:0] comp, input logic wide, input logic msk);
        drain();
        write_reg(REG_COMP_COUNT, comp);
        write_reg(REG_WIDE_BINS, {2'd0, wide});
        write_reg(REG_MASK_EN, {2'd0, msk});
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [16:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Output side: stall pattern, long hold-offs on request, reply check.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (long_req != long_seen) begin
            m_axis_tready <= 1'b0;
            hold_req <= LONG_HOLD;
            long_seen <= long_req;
        end else if (hold_req > 0) begin
            m_axis_tready <= 1'b0;
            hold_req <= hold_req - 1;
        end else if ($urandom_range(0, 63) < 2) begin
            m_axis_tready <= 1'b0;
            hold_req <= $urandom_range(1, 12);
        end else begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        t_reply e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (reply_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply: kind %0d count %0h", m_axis_tuser, m_axis_tdata);
            end else begin
                e = reply_q.pop_front();
                if (e.rkind !== m_axis_tuser || e.cnt !== m_axis_tdata) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reply mismatch: expected kind %0d count %0h, got kind %0d count %0h",
                                 e.rkind, e.cnt, m_axis_tuser, m_axis_tdata);
                end
            end
        end
    end

    // Watchdog: counts cycles with no transfer on any channel.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------
    task automatic test_reset_state();
        send_read(0, 0);
        send_read(1, 1023);
        send_read(0, 255);
    endtask

    task automatic test_pixel_modes();
        // Gray at both ends, then a sample above one that must clamp.
        set_mode(3'd1, 1'b0, 1'b0);
        send_item(KIND_PIXEL, 17'd0, '0, '0, '0, '0, '0, '0);
        send_item(KIND_PIXEL, 17'd65536, '0, '0, '0, '0, '0, '0);
        send_item(KIND_PIXEL, 17'h1FFFF, '0, '0, '0, '0, '0, '0);
        send_read(0, 255);
        send_read(0, 0);
        // Gray alpha with masking and weights above one.
        set_mode(3'd2, 1'b1, 1'b1);
        send_item(KIND_PIXEL, 17'd32768, 17'h1FFFF, '0, '0, 17'd32768, '0, '0);
        send_item(KIND_PIXEL, 17'd32768, 17'd16384, '0, '0, 17'h1FFFF, '0, '0);
        send_read(0, bin_index(17'd32768));
        send_read(1, 1023);
        // RGB and RGBA with the max channel.
        set_mode(3'd4, 1'b1, 1'b0);
        send_item(KIND_PIXEL, 17'd100, 17'd65536, 17'd200, 17'd49152, '0, '0, '0);
        send_read(0, 1023);
        send_read(4, bin_index(17'd49152));
        set_mode(3'd3, 1'b0, 1'b1);
        send_item(KIND_PIXEL, 17'd1000, 17'd2000, 17'd65535, '0, 17'd0, '0, '0);
        send_read(3, bin_index(17'd65535));
        // Invalid component count leaves the store alone; the unused kind is ignored.
        set_mode(3'd0, 1'b0, 1'b0);
        send_item(KIND_PIXEL, 17'd5, 17'd5, 17'd5, 17'd5, '0, '0, '0);
        send_item(KIND_UNUSED, '0, '0, '0, '0, '0, '0, '0);
        set_mode(3'd7, 1'b0, 1'b0);
        send_item(KIND_PIXEL, 17'd5, 17'd5, 17'd5, 17'd5, '0, '0, '0);
        send_read(0, 0);
    endtask

    task automatic test_read_bounds();
        set_mode(3'd2, 1'b0, 1'b0);
        send_read(3, 0);
        send_read(7, 1023);
        send_read(1, 256);
        set_mode(3'd4, 1'b1, 1'b0);
        send_read(5, 3);
        send_read(4, 1023);
    endtask

    task automatic test_clear();
        send_item(KIND_CLEAR, '0, '0, '0, '0, '0, '0, '0);
        send_read(0, 1023);
    endtask

    task automatic test_backpressure();
        set_mode(3'd4, 1'b1, 1'b1);
        long_req++;
        for (int i = 0; i < 40; i++) begin
            if (i % 2 == 0)
                send_item(KIND_PIXEL, rand_sample(), rand_sample(), rand_sample(),
                          rand_sample(), rand_sample(), '0, '0);
            else
                send_read(last_ch, last_bin);
        end
        drain();
    endtask

    task automatic test_random();
        int k;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_mode(3'd1, 1'b0, 1'b0);
                1: set_mode(3'd4, 1'b1, 1'b1);
                2: set_mode(3'd2, 1'b1, 1'b0);
                3: set_mode(3'd3, 1'b0, 1'b1);
                default: set_mode(3'($urandom_range(0, 7)), 1'($urandom), 1'($urandom));
            endcase
            for (int i = 0; i < 225; i++) begin
                k = $urandom_range(0, 999);
                if (k < 3)
                    send_item(KIND_CLEAR, '0, '0, '0, '0, '0, '0, '0);
                else if (k < 10)
                    send_item(KIND_UNUSED, 17'($urandom), '0, '0, '0, '0, 3'($urandom),
                              10'($urandom));
                else if (k < 160)
                    send_read(last_ch, last_bin);
                else if (k < 260)
                    send_read($urandom_range(0, 7), $urandom_range(0, 1023));
                else
                    send_item(KIND_PIXEL, rand_sample(), rand_sample(), rand_sample(),
                              rand_sample(), rand_sample(), '0, '0);
            end
        end
    endtask

    initial begin
        wipe_hist();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_pixel_modes();
        test_read_bounds();
        test_clear();
        test_backpressure();
        test_random();
        drain();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
